FILE: hdl/vmd_pkg.sv
package vmd_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int DEPTH_W    = 11;
  localparam int STEP_W     = 31;
  localparam int PHASE_W    = 32;
  localparam int SINE_W     = 15;
  localparam int DELAY_W    = 28;
  localparam int DIST_W     = 12;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 2;

  localparam int DEF_DELAY_MEM_DEPTH  = 4096;
  localparam int DEF_SINE_TABLE_DEPTH = 1024;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 11'd220;
  localparam logic [STEP_W-1:0]  STEP_RESET  = 31'd447392;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH = 2'd0,
    REG_STEP  = 2'd1
  } reg_idx_t;

  // Unsigned Q0.15 sine of a Q30 angle in the first quadrant, by a Taylor series up to x^13.
  function automatic logic [SINE_W-1:0] sine_q15(input longint x);
    longint x2;
    longint term;
    longint sum;
    longint scaled;
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >>> 30) / 6;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 42;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 72;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 110;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 156;
    sum  = sum + term;
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > ONE_Q30) begin
      sum = ONE_Q30;
    end
    scaled = (sum * 32767 + 64'sd536870912) >>> 30;
    return scaled[SINE_W-1:0];
  endfunction

endpackage

FILE: hdl/vibrato_modulated_delay.sv
// Channel   Ports                                     Direction
// input     in_valid, in_ready, in_sample_in          sample in, one per transaction
// result    out_valid, out_ready, out_sample_out      vibrato sample out, one per input
// config    cfg_wr_en, cfg_index, cfg_data            register write, no wait
//
// Each transaction steps through the sequencer states from acceptance to a loaded result,
// and the next input is taken in the cycle after the result register is loaded, so only
// one transaction is in flight at a time, and a full output register stalls it.
// The sequencer steps are: sine ROM read, delay multiply, a two-step modulo,
// and two reads through the single read port of the delay memory, then the blend multiply.
// Reset is synchronous and immediate; a wrap flag and the write pointer mark entries
// never written, which read as zero, so the delay memory needs no clearing pass.
// A result that is not taken holds the last step until the output register frees.
module vibrato_modulated_delay #(
  parameter int DELAY_MEM_DEPTH  = vmd_pkg::DEF_DELAY_MEM_DEPTH,
  parameter int SINE_TABLE_DEPTH = vmd_pkg::DEF_SINE_TABLE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [vmd_pkg::SAMPLE_W-1:0] in_sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [vmd_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                                cfg_wr_en,
  input  logic [vmd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vmd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import vmd_pkg::*;

  localparam int AW    = $clog2(DELAY_MEM_DEPTH);
  localparam int IW    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW    = 30 + IW;
  localparam int SH    = DIST_W + 1;
  localparam int RW    = SH + 1;
  localparam int QW    = DIST_W + RW;
  localparam int MW    = DIST_W + AW + 1;
  localparam int RECIP = (1 << SH) / DELAY_MEM_DEPTH;
  localparam logic [AW-1:0] LAST = AW'(DELAY_MEM_DEPTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROM,
    ST_DLY,
    ST_MODQ,
    ST_MODR,
    ST_RDA,
    ST_RDB,
    ST_CAPB,
    ST_MUL,
    ST_FIN
  } state_t;

  state_t                     state_r;
  logic [DEPTH_W-1:0]         depth_r;
  logic [STEP_W-1:0]          step_r;
  logic [PHASE_W-1:0]         phase_r;
  logic [AW-1:0]              wp_r;
  logic                       full_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;

  logic [IW-1:0]              idx_r;
  logic [1:0]                 quad_r;
  logic [DELAY_W-1:0]         delay_r;
  logic [DIST_W-1:0]          q_r;
  logic [AW-1:0]              rem_r;
  logic [AW-1:0]              addr_a_r;
  logic [AW-1:0]              addr_b_r;
  logic signed [SAMPLE_W-1:0] a_r;
  logic signed [SAMPLE_W:0]   diff_r;
  logic signed [41:0]         prod_r;

  logic                       in_fire;
  logic                       out_free;
  logic [PW-1:0]              idx_prod;
  logic [IW-1:0]              rom_addr;
  logic [SINE_W-1:0]          rom_data;
  logic signed [17:0]         sine2_s;
  logic signed [11:0]         depth_s;
  logic signed [29:0]         dp;
  logic signed [29:0]         delay_sum;
  logic [DIST_W-1:0]          ip;
  logic [QW-1:0]              q_full;
  logic [MW-1:0]              rem_w;
  logic [MW-1:0]              rem_c;
  logic [AW:0]                addr_sum;
  logic [AW-1:0]              addr_a;
  logic [AW-1:0]              addr_b;
  logic [AW-1:0]              mem_rd_addr;
  logic [SAMPLE_W-1:0]        mem_rd_data;
  logic signed [SAMPLE_W-1:0] tap_a;
  logic signed [SAMPLE_W-1:0] tap_b;
  logic signed [41:0]         blend;
  logic signed [SAMPLE_W-1:0] result;

  assign in_ready       = rst_n && (state_r == ST_IDLE);
  assign in_fire        = in_valid && in_ready;
  assign out_free       = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  assign idx_prod = PW'(phase_r[29:0]) * PW'(SINE_TABLE_DEPTH);
  assign rom_addr = quad_r[0] ? (IW'(SINE_TABLE_DEPTH) - idx_r) : idx_r;

  assign sine2_s   = quad_r[1] ? -$signed({2'b00, rom_data, 1'b0})
                               : $signed({2'b00, rom_data, 1'b0});
  assign depth_s   = $signed({1'b0, depth_r});
  assign dp        = depth_s * sine2_s;
  assign delay_sum = $signed({3'b000, depth_r, 16'h0000}) + dp;

  assign ip     = delay_r[DELAY_W-1:16];
  assign q_full = QW'(ip) * QW'(RECIP);
  assign rem_w  = MW'(ip) - (MW'(q_r) * MW'(DELAY_MEM_DEPTH));
  assign rem_c  = (rem_w >= MW'(DELAY_MEM_DEPTH)) ? (rem_w - MW'(DELAY_MEM_DEPTH)) : rem_w;

  assign addr_sum = (AW + 1)'(wp_r) + (AW + 1)'(DELAY_MEM_DEPTH) - (AW + 1)'(rem_r);
  assign addr_a   = (addr_sum >= (AW + 1)'(DELAY_MEM_DEPTH))
                    ? AW'(addr_sum - (AW + 1)'(DELAY_MEM_DEPTH)) : AW'(addr_sum);
  assign addr_b   = (addr_a_r == '0) ? LAST : (addr_a_r - AW'(1));

  assign mem_rd_addr = (state_r == ST_RDA) ? addr_a : addr_b;

  // Entries not yet written since reset read as zero.
  assign tap_a = (full_r || (addr_a_r <= wp_r)) ? $signed(mem_rd_data) : '0;
  assign tap_b = (full_r || (addr_b_r <= wp_r)) ? $signed(mem_rd_data) : '0;

  assign blend  = $signed({{2{a_r[SAMPLE_W-1]}}, a_r, 16'h0000}) + prod_r + 42'sd32768;
  assign result = blend[39:16];

  vmd_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .IW              (IW)
  ) u_sine_rom (
    .clk    (clk),
    .rd_addr(rom_addr),
    .rd_data(rom_data)
  );

  vmd_delay_mem #(
    .DELAY_MEM_DEPTH(DELAY_MEM_DEPTH),
    .AW             (AW)
  ) u_delay_mem (
    .clk    (clk),
    .wr_en  (in_fire),
    .wr_addr(wp_r),
    .wr_data(in_sample_in),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      depth_r     <= DEPTH_RESET;
      step_r      <= STEP_RESET;
      phase_r     <= '0;
      wp_r        <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_DEPTH: depth_r <= cfg_data[DEPTH_W-1:0];
          REG_STEP:  step_r  <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            phase_r <= phase_r + PHASE_W'(step_r);
            state_r <= ST_ROM;
          end
        end
        ST_ROM:  state_r <= ST_DLY;
        ST_DLY:  state_r <= ST_MODQ;
        ST_MODQ: state_r <= ST_MODR;
        ST_MODR: state_r <= ST_RDA;
        ST_RDA:  state_r <= ST_RDB;
        ST_RDB:  state_r <= ST_CAPB;
        ST_CAPB: state_r <= ST_MUL;
        ST_MUL:  state_r <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            out_sample_r <= result;
            out_valid_r  <= 1'b1;
            if (wp_r == LAST) begin
              wp_r   <= '0;
              full_r <= 1'b1;
            end else begin
              wp_r <= wp_r + AW'(1);
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx_r  <= idx_prod[PW-1:30];
      quad_r <= phase_r[PHASE_W-1:PHASE_W-2];
    end
    if (state_r == ST_DLY) begin
      delay_r <= delay_sum[DELAY_W-1:0];
    end
    if (state_r == ST_MODQ) begin
      q_r <= q_full[SH +: DIST_W];
    end
    if (state_r == ST_MODR) begin
      rem_r <= rem_c[AW-1:0];
    end
    if (state_r == ST_RDA) begin
      addr_a_r <= addr_a;
    end
    if (state_r == ST_RDB) begin
      a_r      <= tap_a;
      addr_b_r <= addr_b;
    end
    if (state_r == ST_CAPB) begin
      diff_r <= $signed({tap_b[SAMPLE_W-1], tap_b}) - $signed({a_r[SAMPLE_W-1], a_r});
    end
    if (state_r == ST_MUL) begin
      prod_r <= diff_r * $signed({1'b0, delay_r[15:0]});
    end
  end

`ifndef NO_ASSERTIONS
  a_wp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= LAST)
    else $error("write pointer beyond the delay memory");

  a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RDA) |-> (rem_r <= LAST))
    else $error("tap distance not reduced below the memory depth");

  a_zero_delay_hits_newest: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RDA && ip == '0) |-> (addr_a == wp_r))
    else $error("zero delay does not read the newest sample");

  a_blend_between_taps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |->
      ((result >= a_r && result <= (a_r + diff_r)) ||
       (result <= a_r && result >= (a_r + diff_r))))
    else $error("interpolated sample outside its two taps");
`endif

endmodule

FILE: hdl/vmd_sine_rom.sv
module vmd_sine_rom #(
  parameter int SINE_TABLE_DEPTH = vmd_pkg::DEF_SINE_TABLE_DEPTH,
  parameter int IW               = $clog2(SINE_TABLE_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic [IW-1:0]             rd_addr,
  output logic [vmd_pkg::SINE_W-1:0] rd_data
);
  import vmd_pkg::*;

  logic [SINE_W-1:0] rom [SINE_TABLE_DEPTH + 1];
  logic [SINE_W-1:0] rd_data_r;

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_entry
    localparam longint ANGLE = (HALF_PI_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
    assign rom[k] = sine_q15(ANGLE);
  end

  always_ff @(posedge clk) begin
    rd_data_r <= rom[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/vmd_delay_mem.sv
module vmd_delay_mem #(
  parameter int DELAY_MEM_DEPTH = vmd_pkg::DEF_DELAY_MEM_DEPTH,
  parameter int AW              = $clog2(DELAY_MEM_DEPTH)
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [vmd_pkg::SAMPLE_W-1:0]  wr_data,
  input  logic [AW-1:0]                 rd_addr,
  output logic [vmd_pkg::SAMPLE_W-1:0]  rd_data
);
  import vmd_pkg::*;

  logic [SAMPLE_W-1:0] mem [DELAY_MEM_DEPTH];
  logic [SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: tb/tb_vibrato_modulated_delay.sv
`timescale 1ns / 1ps

module tb_vibrato_modulated_delay;
  import vmd_pkg::*;

  localparam int  LINE_PTS     = 4096;
  localparam int  SINE_PTS     = 1024;
  localparam int  CYCLE_LIMIT  = 1000000;
  localparam int  SETTLE_CYC   = 12;
  localparam int  NUM_PHASES   = 11;
  localparam int  MAX_REPORTS  = 100;
  localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
  localparam longint UNIT_Q30         = 64'sd1073741824;
  localparam logic [DEPTH_W-1:0] DEPTH_AT_RESET = 11'd220;
  localparam logic [STEP_W-1:0]  STEP_AT_RESET  = 31'd447392;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef enum logic { ROW_WRITE, ROW_SAMPLE } row_kind_t;

  typedef struct packed {
    row_kind_t                    kind;
    logic [CFG_IDX_W-1:0]         idx;
    logic [CFG_DATA_W-1:0]        data;
    logic signed [SAMPLE_W-1:0]   smp;
    logic                         known;
    logic signed [SAMPLE_W-1:0]   want;
  } dir_row_t;

  // Samples with known set carry a result that can be read off directly: an empty line
  // right after reset, and a zero depth that forwards the newest sample.
  dir_row_t dir_rows [0:25] = '{
    '{ROW_SAMPLE, REG_DEPTH,   31'd0,           24'sh7FFFFF, 1'b1, 24'sh000000},
    '{ROW_SAMPLE, REG_DEPTH,   31'd0,           24'sh800000, 1'b1, 24'sh000000},
    '{ROW_SAMPLE, REG_DEPTH,   31'd0,           24'sh000000, 1'b1, 24'sh000000},
    '{ROW_WRITE,  REG_DEPTH,   31'd0,           24'sh000000, 1'b0, 24'sh000000},
    '{ROW_SAMPLE, REG_DEPTH,   31'd0,           24'sh7FFFFF, 1'b1, 24'sh7FFFFF},
    '{ROW_SAMPLE, REG_DEPTH,   31'd0,           24'sh800000, 1'b1, 24'sh800000},
    '{ROW_SAMPLE, REG_DEPTH,   31'd0,           24'shFFFFFF, 1'b1, 24'shFFFFFF},
    '{ROW_SAMPLE, REG_DEPTH,   31'd0,           24'sh000001, 1'b1, 24'sh000001},
    '{ROW_WRITE,  REG_DEPTH,   31'h7FFFF803,    24'sh000000, 1'b0, 24'sh000000},
    '{ROW_SAMPLE, REG_DEPTH,   31'd0,           24'sh123456, 1'b0, 24'sh000000},
    '{ROW_SAMPLE, REG_DEPTH,   31'd0,           24'shABCDEF, 1'b0, 24'sh000000},
    '{ROW_WRITE,  REG_STEP,    31'h40000000,    24'sh000000, 1'b0, 24'sh000000},
    '{ROW_SAMPLE, REG_DEPTH,   31'd0,           24'sh7FFFFF, 1'b0, 24'sh000000},
    '{ROW_SAMPLE, REG_DEPTH,   31'd0,           24'sh800000, 1'b0, 24'sh000000},
    '{ROW_SAMPLE, REG_DEPTH,   31'd0,           24'sh555555, 1'b0, 24'sh000000},
    '{ROW_SAMPLE, REG_DEPTH,   31'd0,           24'shAAAAAA, 1'b0, 24'sh000000},
    '{ROW_WRITE,  REG_DEPTH,   31'd2047,        24'sh000000, 1'b0, 24'sh000000},
    '{ROW_WRITE,  REG_STEP,    31'h7FFFFFFF,    24'sh000000, 1'b0, 24'sh000000},
    '{ROW_SAMPLE, REG_DEPTH,   31'd0,           24'sh0F0F0F, 1'b0, 24'sh000000},
    '{ROW_SAMPLE, REG_DEPTH,   31'd0,           24'shF0F0F0, 1'b0, 24'sh000000},
    '{ROW_WRITE,  REG_SPARE_2, 31'd0,           24'sh000000, 1'b0, 24'sh000000},
    '{ROW_WRITE,  REG_SPARE_3, 31'h12345678,    24'sh000000, 1'b0, 24'sh000000},
    '{ROW_SAMPLE, REG_DEPTH,   31'd0,           24'sh7FFFFF, 1'b0, 24'sh000000},
    '{ROW_SAMPLE, REG_DEPTH,   31'd0,           24'sh800000, 1'b0, 24'sh000000},
    '{ROW_WRITE,  REG_STEP,    31'd0,           24'sh000000, 1'b0, 24'sh000000},
    '{ROW_SAMPLE, REG_DEPTH,   31'd0,           24'sh654321, 1'b0, 24'sh000000}
  };

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [SAMPLE_W-1:0]  in_sample_in = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0]  out_sample_out;
  logic                        cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]        cfg_index = REG_DEPTH;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  logic signed [SAMPLE_W-1:0]  line_mem [0:LINE_PTS-1];
  int                          sine_rom [0:SINE_PTS];
  logic [DIST_W-1:0]           wr_ptr;
  logic [PHASE_W-1:0]          lfo_acc;
  logic [DEPTH_W-1:0]          depth_reg;
  logic [STEP_W-1:0]           step_reg;

  logic signed [SAMPLE_W-1:0]  vib_expect_q [$];
  int                          err_cnt = 0;
  int                          n_in_acc = 0;
  int                          cyc_cnt = 0;

  vibrato_modulated_delay u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint taylor_sin_q30(input longint x);
    longint x2;
    longint term;
    longint sum;
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    for (int n = 3; n <= 13; n += 2) begin
      term = (term * x2) >>> 30;
      term = term / longint'((n - 1) * n);
      if (((n - 1) / 2) % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > UNIT_Q30) begin
      sum = UNIT_Q30;
    end
    return sum;
  endfunction

  function automatic void vibrato_state_reset();
    longint s;
    for (int k = 0; k <= SINE_PTS; k++) begin
      s = taylor_sin_q30((QUARTER_TURN_Q30 * k) / SINE_PTS);
      sine_rom[k] = int'((s * 32767 + 64'sd536870912) >>> 30);
    end
    for (int k = 0; k < LINE_PTS; k++) begin
      line_mem[k] = '0;
    end
    wr_ptr    = '0;
    lfo_acc   = '0;
    depth_reg = DEPTH_AT_RESET;
    step_reg  = STEP_AT_RESET;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] vibrato_predict(
    input logic signed [SAMPLE_W-1:0] smp
  );
    logic [9:0]        idx;
    logic [DIST_W-1:0] ip;
    logic [DIST_W-1:0] tap_a;
    logic [DIST_W-1:0] tap_b;
    longint            sn;
    longint            dly;
    longint            frac;
    longint            a;
    longint            b;
    longint            acc;
    idx = lfo_acc[29:20];
    sn  = lfo_acc[30] ? sine_rom[SINE_PTS - idx] : sine_rom[idx];
    if (lfo_acc[31]) begin
      sn = -sn;
    end
    dly  = longint'(depth_reg) * 65536 + 2 * longint'(depth_reg) * sn;
    ip   = dly[27:16];
    frac = dly & 64'hFFFF;
    line_mem[wr_ptr] = smp;
    tap_a = wr_ptr - ip;
    tap_b = wr_ptr - ip - 12'd1;
    a   = line_mem[tap_a];
    b   = line_mem[tap_b];
    acc = a * (65536 - frac) + b * frac + 32768;
    wr_ptr  = wr_ptr + 12'd1;
    lfo_acc = lfo_acc + {1'b0, step_reg};
    return acc[39:16];
  endfunction

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got,
                                 input logic [SAMPLE_W-1:0] want);
    if (err_cnt < MAX_REPORTS) begin
      $display("MISMATCH %s: sample_out got %h expected %h at cycle %0d",
               what, got, want, cyc_cnt);
    end
    err_cnt++;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic known,
                             input logic signed [SAMPLE_W-1:0] want);
    logic signed [SAMPLE_W-1:0] pred;
    in_valid     <= 1'b1;
    in_sample_in <= smp;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    pred = vibrato_predict(smp);
    vib_expect_q.push_back(known ? want : pred);
    n_in_acc++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (vib_expect_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_DEPTH: depth_reg = data[DEPTH_W-1:0];
      REG_STEP:  step_reg  = data[STEP_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (vib_expect_q.size() == 0) begin
        report_mismatch("no transaction pending", out_sample_out, '0);
      end else if (out_sample_out !== vib_expect_q[0]) begin
        report_mismatch("wrong sample", out_sample_out, vib_expect_q.pop_front());
      end else begin
        void'(vib_expect_q.pop_front());
      end
    end
  end

  // The long hold-off lands inside the long streaming phase, so the input side backs up.
  initial begin
    int rcv_cyc;
    int rcv_mode;
    int hold_left;
    bit hold_done;
    rcv_cyc   = 0;
    rcv_mode  = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      rcv_cyc++;
      if (rcv_cyc % 200 == 0) begin
        rcv_mode = $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && n_in_acc >= 500) begin
        hold_done = 1'b1;
        hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        case (rcv_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          2:       out_ready <= (rcv_cyc % 7) < 4;
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    while (cyc_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc_cnt++;
    end
    $display("tb_vibrato_modulated_delay NOT OK");
    $finish;
  end

  initial begin
    int                         burst_left;
    int                         cnt;
    logic [DEPTH_W-1:0]         nd;
    logic [STEP_W-1:0]          ns;
    logic signed [SAMPLE_W-1:0] smp;
    burst_left = 0;
    vibrato_state_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < $size(dir_rows); r++) begin
      if (dir_rows[r].kind == ROW_WRITE) begin
        cfg_write(dir_rows[r].idx, dir_rows[r].data);
      end else begin
        if (r > 0 && $urandom_range(0, 1) == 1) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        send_sample(dir_rows[r].smp, dir_rows[r].known, dir_rows[r].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          nd = 11'd0;
          ns = 31'd0;
          cnt = 60;
        end
        1: begin
          nd = 11'd2047;
          ns = 31'h7FFFFFFF;
          cnt = 60;
        end
        2: begin
          nd = 11'd1;
          ns = 31'($urandom);
          cnt = 60;
        end
        3: begin
          // One sample that lands the LFO exactly on a quadrant boundary.
          nd = 11'd2047;
          ns = 31'(32'h40000000 - {2'b00, lfo_acc[29:0]});
          cnt = 1;
        end
        4: begin
          nd = 11'd2047;
          ns = 31'h40000000;
          cnt = 12;
        end
        9: begin
          // A long streaming stretch with a deep sweep.
          nd = 11'($urandom_range(1024, 2047));
          ns = 31'($urandom);
          cnt = 340;
        end
        10: begin
          nd = 11'($urandom_range(0, 2047));
          ns = 31'($urandom_range(0, 1 << 20));
          cnt = 100;
        end
        default: begin
          nd = (p % 2 == 1) ? 11'($urandom_range(0, 40)) : 11'($urandom_range(0, 2047));
          ns = 31'($urandom_range(1 << 22, 32'h7FFFFFFF));
          cnt = 60;
        end
      endcase
      cfg_write(REG_DEPTH, {20'($urandom), nd});
      cfg_write(REG_STEP, ns);
      burst_left = 0;
      for (int k = 0; k < cnt; k++) begin
        if (cnt > 20 && k == cnt / 2) begin
          wait_drained();
        end
        if (burst_left == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 24);
        end
        burst_left--;
        case ($urandom_range(0, 15))
          0:       smp = 24'sh7FFFFF;
          1:       smp = 24'sh800000;
          default: smp = 24'($urandom);
        endcase
        send_sample(smp, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_vibrato_modulated_delay OK");
    end else begin
      $display("tb_vibrato_modulated_delay NOT OK");
    end
    $finish;
  end

endmodule
